// ----- sv/gdss_pkg.sv -----
// Package for the gyro dead-zone, scale and smoothing filter.
// Holds action and kind codes, register indexes and fixed output constants.
// No dependencies.
package gdss_pkg;

  typedef logic [1:0] action_t;
  typedef logic [1:0] kind_t;

  // Input actions.
  localparam action_t ACT_SAMPLE     = 2'd0;
  localparam action_t ACT_ACTIVATE   = 2'd1;
  localparam action_t ACT_DEACTIVATE = 2'd2;
  localparam action_t ACT_RECAL      = 2'd3;

  // What the back end does with a queued beat.
  localparam kind_t KIND_ZERO   = 2'd0;  // zero result, smoothing state kept
  localparam kind_t KIND_CLEAR  = 2'd1;  // zero result, smoothing state cleared
  localparam kind_t KIND_SAMPLE = 2'd2;  // scale and blend

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING   = 3'd5;

  localparam int DZ_W    = 16;
  localparam int SENS_W  = 10;
  localparam int SMOOTH_W = 9;
  localparam int OUT_W   = 18;

  localparam logic [SENS_W-1:0]   SENS_RESET = 10'd256;
  localparam logic [SENS_W-1:0]   SENS_MIN   = 10'd26;
  localparam logic [SENS_W-1:0]   SENS_MAX   = 10'd768;
  localparam logic [SMOOTH_W-1:0] SMOOTH_ONE = 9'd256;

  localparam logic signed [OUT_W-1:0] OUT_MIN = 18'sh20000;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sh1FFFF;

endpackage

// ----- sv/gdss_if.sv -----
// Channel interfaces for the gyro filter: sample input and camera delta output.
// Depends on nothing; input widths follow the SAMPLE_BITS parameter, output deltas are 18 bits.
interface gdss_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic signed [SAMPLE_BITS-1:0] gyro_x;
  logic signed [SAMPLE_BITS-1:0] gyro_y;
  logic signed [SAMPLE_BITS-1:0] gyro_z;

  modport source (output valid, action, gyro_x, gyro_y, gyro_z, input ready);
  modport sink   (input valid, action, gyro_x, gyro_y, gyro_z, output ready);
endinterface

interface gdss_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] yaw_delta;
  logic signed [17:0] pitch_delta;

  modport source (output valid, yaw_delta, pitch_delta, input ready);
  modport sink   (input valid, yaw_delta, pitch_delta, output ready);
endinterface

// ----- sv/gyro_deadzone_scale_smooth_top.sv -----
// Top level of the gyro dead-zone, sensitivity and smoothing filter.
// Holds the configuration registers; depends on gdss_pkg, the channel
// interfaces, gdss_front, gdss_queue and gdss_back.
//
//   channel   direction  payload                              beat taken when
//   in_ch     in         action, gyro_x, gyro_y, gyro_z       valid && ready
//   out_ch    out        yaw_delta, pitch_delta               valid && ready
//   cfg_*     in         cfg_index, cfg_data                  cfg_we
//
// Every input beat yields exactly one output beat. The front end takes a beat
// through accept, two squaring steps for the dead-zone test and push, and
// takes no new beat until that one is pushed; the back end's steps (pop,
// scale, blend, saturate) keep pace with it, and non-samples skip scale and blend.
// Reset is synchronous and active low; it clears the active flag, the stored
// previous output and the registers, with sensitivity returning to 1.0.
// A stalled output does not stop the front end: up to two classified beats
// wait in the queue while the back end holds its result.
module gyro_deadzone_scale_smooth_top #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  gdss_in_if.sink    in_ch,
  gdss_out_if.source out_ch,
  input  logic                             cfg_we,
  input  logic [gdss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16)-1:0] cfg_data
);

  localparam int CAL_W = SAMPLE_BITS + 1;
  localparam int Q_W   = 2 * CAL_W + 2;

  // Calibration and filter settings; software must write them only while idle, and the block has no check for it.
  logic signed [SAMPLE_BITS-1:0]      offset_x_r, offset_y_r, offset_z_r;
  logic [gdss_pkg::DZ_W-1:0]          dead_zone_r;
  logic [gdss_pkg::SENS_W-1:0]        sensitivity_r;
  logic [gdss_pkg::SMOOTH_W-1:0]      smoothing_r;

  logic           q_push_valid, q_push_ready;
  logic [Q_W-1:0] q_push_data;
  logic           q_pop_valid, q_pop_ready;
  logic [Q_W-1:0] q_pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r    <= '0;
      offset_y_r    <= '0;
      offset_z_r    <= '0;
      dead_zone_r   <= '0;
      sensitivity_r <= gdss_pkg::SENS_RESET;
      smoothing_r   <= '0;
    end else if (cfg_we) begin
      // Writes to an index beyond the register list are dropped.
      unique case (cfg_index)
        gdss_pkg::REG_OFFSET_X:    offset_x_r    <= cfg_data[SAMPLE_BITS-1:0];
        gdss_pkg::REG_OFFSET_Y:    offset_y_r    <= cfg_data[SAMPLE_BITS-1:0];
        gdss_pkg::REG_OFFSET_Z:    offset_z_r    <= cfg_data[SAMPLE_BITS-1:0];
        gdss_pkg::REG_DEAD_ZONE:   dead_zone_r   <= cfg_data[gdss_pkg::DZ_W-1:0];
        gdss_pkg::REG_SENSITIVITY: sensitivity_r <= cfg_data[gdss_pkg::SENS_W-1:0];
        gdss_pkg::REG_SMOOTHING:   smoothing_r   <= cfg_data[gdss_pkg::SMOOTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front end classifies each beat and runs the dead-zone test.
  gdss_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .offset_x   (offset_x_r),
    .offset_y   (offset_y_r),
    .offset_z   (offset_z_r),
    .dead_zone  (dead_zone_r),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  // Decouples the two ends so each can stall on its own.
  gdss_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  // The back end scales, blends with the previous output and saturates.
  gdss_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (q_pop_valid),
    .pop_ready   (q_pop_ready),
    .pop_data    (q_pop_data),
    .sensitivity (sensitivity_r),
    .smoothing   (smoothing_r),
    .out_ch      (out_ch)
  );

endmodule

// ----- sv/gdss_queue.sv -----
// Two-entry queue between the front and back ends of the gyro filter.
// Generic payload vector; no package dependency.
module gdss_queue #(
  parameter int WIDTH = 36
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// ----- sv/gdss_front.sv -----
// Front end of the gyro filter: accepts beats, tracks the active flag,
// removes offsets and runs the dead-zone test. Depends on gdss_pkg, gdss_in_if.
module gdss_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  gdss_in_if.sink                       in_ch,
  input  logic signed [SAMPLE_BITS-1:0] offset_x,
  input  logic signed [SAMPLE_BITS-1:0] offset_y,
  input  logic signed [SAMPLE_BITS-1:0] offset_z,
  input  logic [gdss_pkg::DZ_W-1:0]     dead_zone,
  output logic                          push_valid,
  input  logic                          push_ready,
  output logic [2*SAMPLE_BITS+3:0]      push_data
);

  localparam int CAL_W = SAMPLE_BITS + 1;
  localparam int SQ_W  = 2 * CAL_W;
  localparam int DZ2_W = 2 * gdss_pkg::DZ_W;
  localparam int MAG_W = (SQ_W > DZ2_W) ? SQ_W : DZ2_W;

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_SQ1  = 2'd1;
  localparam logic [1:0] FS_SQ2  = 2'd2;
  localparam logic [1:0] FS_PUSH = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic                    active_r;
  gdss_pkg::kind_t         kind_r, kind_acc;
  logic signed [CAL_W-1:0] cal_x_r, cal_y_r, cal_z_r;
  logic signed [SQ_W-1:0]  sq_a, sq_b, sq_c;
  logic [SQ_W-1:0]         sq_a_r, sq_b_r, sq_c_r;
  logic [MAG_W-1:0]        sum_ab_r;
  logic [DZ2_W-1:0]        dz2_r;
  logic [MAG_W-1:0]        mag2;
  gdss_pkg::kind_t         kind_out;
  logic                    accept;

  assign in_ch.ready = (state_r == FS_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    unique case (in_ch.action) inside
      gdss_pkg::ACT_SAMPLE:
        kind_acc = active_r ? gdss_pkg::KIND_SAMPLE : gdss_pkg::KIND_ZERO;
      gdss_pkg::ACT_DEACTIVATE, gdss_pkg::ACT_RECAL:
        kind_acc = gdss_pkg::KIND_CLEAR;
      default:
        kind_acc = gdss_pkg::KIND_ZERO;
    endcase
  end

  assign sq_a = cal_x_r * cal_x_r;
  assign sq_b = cal_y_r * cal_y_r;
  assign sq_c = cal_z_r * cal_z_r;

  // Squares are never negative, so the sum runs unsigned.
  assign mag2 = sum_ab_r + MAG_W'(sq_c_r);

  always_comb begin
    kind_out = kind_r;
    if (kind_r == gdss_pkg::KIND_SAMPLE && mag2 < MAG_W'(dz2_r)) begin
      kind_out = gdss_pkg::KIND_ZERO;
    end
  end

  assign push_valid = (state_r == FS_PUSH);
  assign push_data  = {kind_out, cal_x_r, cal_y_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_IDLE: if (accept) state_nxt = FS_SQ1;
      FS_SQ1:  state_nxt = FS_SQ2;
      FS_SQ2:  state_nxt = FS_PUSH;
      FS_PUSH: if (push_ready) state_nxt = FS_IDLE;
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= FS_IDLE;
      active_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (in_ch.action == gdss_pkg::ACT_ACTIVATE) begin
          active_r <= 1'b1;
        end else if (in_ch.action == gdss_pkg::ACT_DEACTIVATE) begin
          active_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= kind_acc;
      cal_x_r <= CAL_W'(in_ch.gyro_x) - CAL_W'(offset_x);
      cal_y_r <= CAL_W'(in_ch.gyro_y) - CAL_W'(offset_y);
      cal_z_r <= CAL_W'(in_ch.gyro_z) - CAL_W'(offset_z);
    end
    if (state_r == FS_SQ1) begin
      sq_a_r <= sq_a;
      sq_b_r <= sq_b;
    end
    if (state_r == FS_SQ2) begin
      sum_ab_r <= MAG_W'(sq_a_r) + MAG_W'(sq_b_r);
      sq_c_r   <= sq_c;
      dz2_r    <= dead_zone * dead_zone;
    end
  end

endmodule

// ----- sv/gdss_back.sv -----
// Back end of the gyro filter: scales, blends with the previous output,
// saturates and holds the result beat. Depends on gdss_pkg, gdss_out_if.
module gdss_back #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  logic [2*SAMPLE_BITS+3:0]      pop_data,
  input  logic [gdss_pkg::SENS_W-1:0]   sensitivity,
  input  logic [gdss_pkg::SMOOTH_W-1:0] smoothing,
  gdss_out_if.source                    out_ch
);

  localparam int CAL_W   = SAMPLE_BITS + 1;
  localparam int PROD_W  = CAL_W + gdss_pkg::SENS_W + 1;
  localparam int SC_W    = PROD_W - 8;
  localparam int PREV_W  = gdss_pkg::OUT_W + gdss_pkg::SMOOTH_W + 1;
  localparam int WSC_W   = SC_W + gdss_pkg::SMOOTH_W + 1;
  localparam int SUM_W   = ((PREV_W > WSC_W) ? PREV_W : WSC_W) + 1;
  localparam int SHR_W   = SUM_W - 8;

  localparam logic [1:0] BS_IDLE  = 2'd0;
  localparam logic [1:0] BS_SCALE = 2'd1;
  localparam logic [1:0] BS_MIX   = 2'd2;
  localparam logic [1:0] BS_FIN   = 2'd3;

  logic [1:0]                           state_r, state_nxt;
  gdss_pkg::kind_t                      kind_r;
  logic signed [CAL_W-1:0]              cal_x_r, cal_y_r;
  logic signed [gdss_pkg::OUT_W-1:0]    prev_yaw_r, prev_pitch_r;
  logic [gdss_pkg::SENS_W-1:0]          sens_c;
  logic [gdss_pkg::SMOOTH_W-1:0]        s_c, inv_s;
  logic signed [PROD_W-1:0]             prod_y, prod_p;
  logic signed [SC_W-1:0]               sc_y_r, sc_p_r;
  logic signed [PREV_W-1:0]             pp_y, pp_p, pp_y_r, pp_p_r;
  logic signed [WSC_W-1:0]              wsc_y, wsc_p, wsc_y_r, wsc_p_r;
  logic signed [SUM_W-1:0]              sum_y, sum_p;
  logic signed [SHR_W-1:0]              shr_y, shr_p;
  logic signed [gdss_pkg::OUT_W-1:0]    res_y, res_p;
  logic                                 out_valid_r;
  logic signed [gdss_pkg::OUT_W-1:0]    out_yaw_r, out_pitch_r;
  logic                                 slot_free;
  logic                                 finish;

  function automatic logic signed [gdss_pkg::OUT_W-1:0] sat_out(
    input logic signed [SHR_W-1:0] v
  );
    logic fits;
    fits = (v[SHR_W-1:gdss_pkg::OUT_W-1] == '0) || (v[SHR_W-1:gdss_pkg::OUT_W-1] == '1);
    if (fits) begin
      sat_out = v[gdss_pkg::OUT_W-1:0];
    end else if (v[SHR_W-1]) begin
      sat_out = gdss_pkg::OUT_MIN;
    end else begin
      sat_out = gdss_pkg::OUT_MAX;
    end
  endfunction

  // Registers are clamped at use, as written values may lie outside the range.
  always_comb begin
    if (sensitivity < gdss_pkg::SENS_MIN) begin
      sens_c = gdss_pkg::SENS_MIN;
    end else if (sensitivity > gdss_pkg::SENS_MAX) begin
      sens_c = gdss_pkg::SENS_MAX;
    end else begin
      sens_c = sensitivity;
    end
    s_c   = (smoothing > gdss_pkg::SMOOTH_ONE) ? gdss_pkg::SMOOTH_ONE : smoothing;
    inv_s = gdss_pkg::SMOOTH_ONE - s_c;
  end

  assign prod_y = cal_y_r * $signed({1'b0, sens_c});
  assign prod_p = cal_x_r * $signed({1'b0, sens_c});
  assign pp_y   = prev_yaw_r * $signed({1'b0, s_c});
  assign pp_p   = prev_pitch_r * $signed({1'b0, s_c});
  assign wsc_y  = sc_y_r * $signed({1'b0, inv_s});
  assign wsc_p  = sc_p_r * $signed({1'b0, inv_s});
  assign sum_y  = SUM_W'(pp_y_r) + SUM_W'(wsc_y_r);
  assign sum_p  = SUM_W'(pp_p_r) + SUM_W'(wsc_p_r);
  // Arithmetic shift right by eight is a floor division by 256.
  assign shr_y  = sum_y[SUM_W-1:8];
  assign shr_p  = sum_p[SUM_W-1:8];

  always_comb begin
    if (kind_r == gdss_pkg::KIND_SAMPLE) begin
      res_y = sat_out(shr_y);
      res_p = sat_out(shr_p);
    end else begin
      res_y = '0;
      res_p = '0;
    end
  end

  assign slot_free          = !out_valid_r || out_ch.ready;
  assign finish             = (state_r == BS_FIN) && slot_free;
  assign pop_ready          = (state_r == BS_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.yaw_delta   = out_yaw_r;
  assign out_ch.pitch_delta = out_pitch_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE: begin
        if (pop_valid) begin
          state_nxt = (pop_data[2*CAL_W+1:2*CAL_W] == gdss_pkg::KIND_SAMPLE) ?
                      BS_SCALE : BS_FIN;
        end
      end
      BS_SCALE: state_nxt = BS_MIX;
      BS_MIX:   state_nxt = BS_FIN;
      BS_FIN:   if (slot_free) state_nxt = BS_IDLE;
      default:  state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BS_IDLE;
      out_valid_r  <= 1'b0;
      prev_yaw_r   <= '0;
      prev_pitch_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
        if (kind_r == gdss_pkg::KIND_SAMPLE) begin
          prev_yaw_r   <= res_y;
          prev_pitch_r <= res_p;
        end else if (kind_r == gdss_pkg::KIND_CLEAR) begin
          prev_yaw_r   <= '0;
          prev_pitch_r <= '0;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      kind_r  <= pop_data[2*CAL_W+1:2*CAL_W];
      cal_x_r <= pop_data[2*CAL_W-1:CAL_W];
      cal_y_r <= pop_data[CAL_W-1:0];
    end
    if (state_r == BS_SCALE) begin
      sc_y_r <= prod_y[PROD_W-1:8];
      sc_p_r <= prod_p[PROD_W-1:8];
      pp_y_r <= pp_y;
      pp_p_r <= pp_p;
    end
    if (state_r == BS_MIX) begin
      wsc_y_r <= wsc_y;
      wsc_p_r <= wsc_p;
    end
    if (finish) begin
      out_yaw_r   <= res_y;
      out_pitch_r <= res_p;
    end
  end

endmodule

// ----- tb/sv/gdss_delta_checker.sv -----
`timescale 1ns / 100ps
// Checker for the gyro filter: watches the sample, delta and register ports,
// predicts every camera delta and compares it with the one the block sends.
// Depends on gdss_pkg and the channel interfaces in gdss_if.sv.
module gdss_delta_checker (
  input  logic        clk,
  input  logic        rst_n,
  gdss_in_if          in_mon,
  gdss_out_if         out_mon,
  input  logic        cfg_we,
  input  logic [gdss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  typedef struct {
    logic signed [gdss_pkg::OUT_W-1:0] yaw;
    logic signed [gdss_pkg::OUT_W-1:0] pitch;
  } delta_t;

  logic signed [15:0]                 off_x, off_y, off_z;
  logic [gdss_pkg::DZ_W-1:0]          dead_zone;
  logic [gdss_pkg::SENS_W-1:0]        sens_reg;
  logic [gdss_pkg::SMOOTH_W-1:0]      smooth_reg;
  bit                                 active;
  logic signed [gdss_pkg::OUT_W-1:0]  prev_yaw, prev_pitch;
  delta_t                             expected_deltas[$];
  delta_t                             got_delta, want_delta;

  task automatic flag_mismatch(input string what,
                               input logic signed [gdss_pkg::OUT_W-1:0] want,
                               input logic signed [gdss_pkg::OUT_W-1:0] got);
    $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // Scale one axis, blend it with the previous output and saturate.
  function automatic logic signed [gdss_pkg::OUT_W-1:0] blend_axis(
    longint prev, longint cal, longint gain, longint weight
  );
    longint scaled, mixed;
    scaled = (cal * gain) >>> 8;
    mixed  = (prev * weight + scaled * (256 - weight)) >>> 8;
    if (mixed < longint'(gdss_pkg::OUT_MIN)) mixed = longint'(gdss_pkg::OUT_MIN);
    if (mixed > longint'(gdss_pkg::OUT_MAX)) mixed = longint'(gdss_pkg::OUT_MAX);
    return mixed[gdss_pkg::OUT_W-1:0];
  endfunction

  task automatic predict_delta(input gdss_pkg::action_t act, input logic signed [15:0] gx,
                               input logic signed [15:0] gy, input logic signed [15:0] gz,
                               output delta_t d);
    longint cx, cy, cz, mag2, dz, gain, weight;
    d.yaw   = '0;
    d.pitch = '0;
    case (act)
      gdss_pkg::ACT_ACTIVATE: active = 1'b1;
      gdss_pkg::ACT_DEACTIVATE: begin
        active     = 1'b0;
        prev_yaw   = '0;
        prev_pitch = '0;
      end
      gdss_pkg::ACT_RECAL: begin
        prev_yaw   = '0;
        prev_pitch = '0;
      end
      default: begin
        if (active) begin
          cx   = longint'(gx) - longint'(off_x);
          cy   = longint'(gy) - longint'(off_y);
          cz   = longint'(gz) - longint'(off_z);
          mag2 = cx * cx + cy * cy + cz * cz;
          dz   = dead_zone;
          if (mag2 >= dz * dz) begin
            gain   = sens_reg;
            weight = smooth_reg;
            if (gain < longint'(gdss_pkg::SENS_MIN)) gain = gdss_pkg::SENS_MIN;
            if (gain > longint'(gdss_pkg::SENS_MAX)) gain = gdss_pkg::SENS_MAX;
            if (weight > longint'(gdss_pkg::SMOOTH_ONE)) weight = gdss_pkg::SMOOTH_ONE;
            d.yaw      = blend_axis(prev_yaw, cy, gain, weight);
            d.pitch    = blend_axis(prev_pitch, cx, gain, weight);
            prev_yaw   = d.yaw;
            prev_pitch = d.pitch;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      off_x      = '0;
      off_y      = '0;
      off_z      = '0;
      dead_zone  = '0;
      sens_reg   = gdss_pkg::SENS_RESET;
      smooth_reg = '0;
      active     = 1'b0;
      prev_yaw   = '0;
      prev_pitch = '0;
      expected_deltas.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gdss_pkg::REG_OFFSET_X:    off_x      = cfg_data;
          gdss_pkg::REG_OFFSET_Y:    off_y      = cfg_data;
          gdss_pkg::REG_OFFSET_Z:    off_z      = cfg_data;
          gdss_pkg::REG_DEAD_ZONE:   dead_zone  = cfg_data;
          gdss_pkg::REG_SENSITIVITY: sens_reg   = cfg_data[gdss_pkg::SENS_W-1:0];
          gdss_pkg::REG_SMOOTHING:   smooth_reg = cfg_data[gdss_pkg::SMOOTH_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_delta(in_mon.action, in_mon.gyro_x, in_mon.gyro_y, in_mon.gyro_z,
                      want_delta);
        expected_deltas.push_back(want_delta);
      end
      if (out_mon.valid && out_mon.ready) begin
        got_delta.yaw   = out_mon.yaw_delta;
        got_delta.pitch = out_mon.pitch_delta;
        if (expected_deltas.size() == 0) begin
          flag_mismatch("delta beat with nothing expected, yaw", '0, got_delta.yaw);
        end else begin
          want_delta = expected_deltas.pop_front();
          if (got_delta.yaw !== want_delta.yaw)
            flag_mismatch("yaw_delta", want_delta.yaw, got_delta.yaw);
          if (got_delta.pitch !== want_delta.pitch)
            flag_mismatch("pitch_delta", want_delta.pitch, got_delta.pitch);
        end
      end
    end
    outstanding = expected_deltas.size();
  end

endmodule

// ----- tb/sv/gyro_deadzone_scale_smooth_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the gyro dead-zone, sensitivity and smoothing filter.
// Depends on gdss_pkg, gdss_if.sv, the block and gdss_delta_checker.
module gyro_deadzone_scale_smooth_top_tb;

  // Register indexes past the end of the list; writes there must be ignored.
  localparam logic [gdss_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [gdss_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam int PHASE_BEATS = 115;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [gdss_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;
  int          mismatches;
  int          outstanding;
  // When set, neither the sender nor the receiver inserts idle cycles.
  bit          steady;

  gdss_in_if #(.SAMPLE_BITS(16)) in_ch ();
  gdss_out_if                    out_ch ();

  gyro_deadzone_scale_smooth_top #(.SAMPLE_BITS(16)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The checker sees every beat on both channels and every register write,
  // so it keeps its own copy of the registers and the smoothing state.
  gdss_delta_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // All stimulus changes at the falling edge; the block and the checker look
  // at the rising edge, so nothing depends on ordering inside a time step.
  // Every task below is entered and left at a falling edge.

  task automatic send_beat(input gdss_pkg::action_t act, input logic signed [15:0] gx,
                           input logic signed [15:0] gy, input logic signed [15:0] gz);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.gyro_x <= gx;
    in_ch.gyro_y <= gy;
    in_ch.gyro_z <= gz;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every delta still owed has been taken. Every
  // beat yields exactly one delta, so nothing is left inside the block then.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [gdss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic program_regs(input logic signed [15:0] ox, input logic signed [15:0] oy,
                              input logic signed [15:0] oz, input logic [15:0] dz,
                              input logic [gdss_pkg::SENS_W-1:0] sens,
                              input logic [gdss_pkg::SMOOTH_W-1:0] sm);
    cfg_write(gdss_pkg::REG_OFFSET_X, ox);
    cfg_write(gdss_pkg::REG_OFFSET_Y, oy);
    cfg_write(gdss_pkg::REG_OFFSET_Z, oz);
    cfg_write(gdss_pkg::REG_DEAD_ZONE, dz);
    cfg_write(gdss_pkg::REG_SENSITIVITY, 16'(sens));
    cfg_write(gdss_pkg::REG_SMOOTHING, 16'(sm));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One setting of the registers followed by a run of random beats. Most
  // beats are samples; an activate opens the phase so they get past the
  // active check, and the occasional deactivate or recalibrate breaks the
  // smoothing history. Axis values lean toward the offsets so that the
  // dead-zone edge gets hit, with full-scale extremes mixed in.
  task automatic run_phase(input logic signed [15:0] ox, input logic signed [15:0] oy,
                           input logic signed [15:0] oz, input logic [15:0] dz,
                           input logic [gdss_pkg::SENS_W-1:0] sens,
                           input logic [gdss_pkg::SMOOTH_W-1:0] sm,
                           input int beats);
    gdss_pkg::action_t act;
    logic signed [15:0] axis[3];
    logic signed [15:0] centre[3];
    int spread, pick;
    settle();
    program_regs(ox, oy, oz, dz, sens, sm);
    send_beat(gdss_pkg::ACT_ACTIVATE, 16'($urandom), 16'($urandom), 16'($urandom));
    centre[0] = ox;
    centre[1] = oy;
    centre[2] = oz;
    spread = int'(dz) + 16;
    repeat (beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 82)      act = gdss_pkg::ACT_SAMPLE;
      else if (pick < 90) act = gdss_pkg::ACT_ACTIVATE;
      else if (pick < 94) act = gdss_pkg::ACT_DEACTIVATE;
      else                act = gdss_pkg::ACT_RECAL;
      for (int a = 0; a < 3; a++) begin
        case ($urandom_range(0, 9))
          0: axis[a] = 16'sh8000;
          1: axis[a] = 16'sh7FFF;
          2, 3, 4: axis[a] = centre[a] + 16'(int'($urandom_range(0, 2 * spread)) - spread);
          default: axis[a] = 16'($urandom);
        endcase
      end
      send_beat(act, axis[0], axis[1], axis[2]);
    end
  endtask

  // The receiver draws a stall of random length for every delta beat, with none while steady is set.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // Guard against a hang. The slowest legal run is about a thousand beats,
  // well under a third of a millisecond.
  initial begin
    #2_000_000;
    $display("FAIL gyro_deadzone_scale_smooth_top");
    $finish;
  end

  initial begin
    logic signed [15:0] ox, oy, oz;
    logic [15:0]        dz;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    steady       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = gdss_pkg::ACT_SAMPLE;
    in_ch.gyro_x = '0;
    in_ch.gyro_y = '0;
    in_ch.gyro_z = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings: unity gain, no smoothing and
    // no dead zone. A sample before activation must come out as zero.
    send_beat(gdss_pkg::ACT_SAMPLE, 16'sd100, 16'sd200, 16'sd300);
    send_beat(gdss_pkg::ACT_ACTIVATE, '0, '0, '0);
    send_beat(gdss_pkg::ACT_SAMPLE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_beat(gdss_pkg::ACT_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000);
    send_beat(gdss_pkg::ACT_SAMPLE, '0, '0, '0);
    send_beat(gdss_pkg::ACT_RECAL, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_beat(gdss_pkg::ACT_SAMPLE, 16'sd1, -16'sd1, 16'sd5);
    send_beat(gdss_pkg::ACT_DEACTIVATE, '0, '0, '0);
    send_beat(gdss_pkg::ACT_SAMPLE, 16'sd500, 16'sd500, 16'sd500);
    send_beat(gdss_pkg::ACT_ACTIVATE, '0, '0, '0);

    // Small offsets, a dead zone of five, an over-range gain that clamps to
    // 3.0 and half smoothing. Writes past the register list come first and
    // must leave everything alone.
    settle();
    cfg_write(REG_SPARE_A, 16'hFFFF);
    cfg_write(REG_SPARE_B, 16'hFFFF);
    program_regs(16'sd1, -16'sd1, 16'sd2, 16'd5, 10'd1023, 9'd128);
    send_beat(gdss_pkg::ACT_ACTIVATE, '0, '0, '0);
    // Calibrated vector (3, 4, 0) sits exactly on the dead-zone edge and
    // passes; (2, 2, 4) falls just inside and yields zero.
    send_beat(gdss_pkg::ACT_SAMPLE, 16'sd4, 16'sd3, 16'sd2);
    send_beat(gdss_pkg::ACT_SAMPLE, 16'sd3, 16'sd1, 16'sd6);
    send_beat(gdss_pkg::ACT_SAMPLE, 16'sh7FFF, 16'sh8000, '0);
    send_beat(gdss_pkg::ACT_SAMPLE, 16'sh8000, 16'sh7FFF, '0);
    send_beat(gdss_pkg::ACT_RECAL, '0, '0, '0);
    send_beat(gdss_pkg::ACT_SAMPLE, 16'sd1000, -16'sd1000, '0);

    // Fixed settings at the extremes: full gain with saturation and no
    // idling at all; extreme offsets with the widest dead zone, a gain of
    // zero and smoothing past one; a dead zone of one with full smoothing;
    // the lowest legal gain with smoothing just past one.
    steady = 1'b1;
    run_phase('0, '0, '0, 16'd0, 10'd768, 9'd0, PHASE_BEATS);
    steady = 1'b0;
    run_phase(16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFF, 10'd0, 9'd511, PHASE_BEATS);
    run_phase(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'd1, 10'd1023, 9'd256, PHASE_BEATS);
    run_phase('0, '0, '0, 16'd300, 10'd26, 9'd257, PHASE_BEATS);

    // Random settings, mostly with offsets and dead zones that let samples
    // through, now and then with stretches of no idling.
    repeat (4) begin
      ox = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400)) - 16'sd200;
      oy = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400)) - 16'sd200;
      oz = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400)) - 16'sd200;
      case ($urandom_range(0, 3))
        0: dz = '0;
        1: dz = 16'($urandom_range(0, 64));
        2: dz = 16'($urandom_range(0, 2000));
        default: dz = 16'($urandom);
      endcase
      steady = ($urandom_range(0, 3) == 0);
      run_phase(ox, oy, oz, dz, 10'($urandom_range(0, 1023)),
                ($urandom_range(0, 3) == 0) ? 9'($urandom_range(257, 511))
                                             : 9'($urandom_range(0, 256)),
                PHASE_BEATS);
    end

    // Wait for the last deltas, then a little longer so that any stray
    // beat from the block is still caught.
    settle();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS gyro_deadzone_scale_smooth_top");
    end else begin
      $display("FAIL gyro_deadzone_scale_smooth_top");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/gdss_pkg.sv
sv/gdss_if.sv
sv/gdss_queue.sv
sv/gdss_front.sv
sv/gdss_back.sv
sv/gyro_deadzone_scale_smooth_top.sv
tb/sv/gdss_delta_checker.sv
tb/sv/gyro_deadzone_scale_smooth_top_tb.sv
